### sv/gastar_pkg.sv
`default_nettype none
package gastar_pkg;

   localparam int GRID_SIDE      = 32;
   localparam int COORD_W        = 5;
   localparam int CELL_W         = 2 * COORD_W;
   localparam int CELLS          = GRID_SIDE * GRID_SIDE;
   localparam int DIM_W          = 6;
   localparam int LEN_W          = CELL_W + 1;
   localparam int COST_FRAC_BITS = 8;
   localparam int COST_W         = 24;
   localparam int F_W            = COST_W + 1;
   localparam int SEQ_W          = 24;

   localparam logic [COST_W-1:0] COST_MAX      = {COST_W{1'b1}};
   localparam logic [COST_W-1:0] STRAIGHT_COST = COST_W'(1 << COST_FRAC_BITS);
   // sqrt(2) in Q8, rounded to nearest
   localparam logic [COST_W-1:0] DIAG_COST     = COST_W'(362);

   // heuristic square root: operand is (dx^2 + dy^2) << (2 * frac bits)
   localparam int SUMSQ_W  = 2 * COORD_W + 1;
   localparam int SQRT_V_W = SUMSQ_W + 2 * COST_FRAC_BITS + 1;
   localparam int SQRT_R_W = SQRT_V_W / 2;

   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_FIND    = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FOUND    = 2'd1;
   localparam logic [1:0] ST_NO_PATH  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // neighbour order: four straight steps, then four diagonals
   localparam logic signed [1:0] STEP_DX [8] =
      '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
   localparam logic signed [1:0] STEP_DY [8] =
      '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1};

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               blocked;
      logic [COORD_W-1:0] goal_x;
      logic [COORD_W-1:0] goal_y;
      logic [CELL_W-1:0]  path_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [LEN_W-1:0]   path_length;
      logic [COORD_W-1:0] path_x;
      logic [COORD_W-1:0] path_y;
   } rsp_item_type;

   typedef struct packed {
      logic [F_W-1:0]    f;
      logic [SEQ_W-1:0]  seq;
      logic [CELL_W-1:0] cell_id;
   } heap_entry_type;

   typedef struct packed {
      logic              closed;
      logic [COST_W-1:0] cost;
   } cost_entry_type;

   typedef enum logic [4:0] {
      S_MAP_CLR, S_IDLE, S_RD_WAIT, S_RESP, S_GOAL_CHK, S_COST_CLR, S_START,
      S_START_H, S_UP, S_UP_CMP, S_POP, S_POP_TOP, S_POP_LAST, S_DN, S_DN_L,
      S_DN_R, S_EXP_RD, S_EXP_CHK, S_NB, S_NB_BLK, S_NB_COST, S_NB_H,
      S_NB_NEXT, S_PL, S_PL_WAIT, S_PW, S_PW_WAIT
   } gastar_state_type;

   // lower f first, equal f goes to the earlier push
   function automatic logic heap_before(heap_entry_type a, heap_entry_type b);
      return {a.f, a.seq} < {b.f, b.seq};
   endfunction

endpackage
`default_nettype wire

### sv/grid_astar_path_search.sv
`default_nettype none
// A* path search over a 32 x 32 map of open or blocked cells, 8-connected,
// with Q8 step costs (straight 256, diagonal 362) and a square-root
// Euclidean heuristic. After reset the block sweeps the map RAM to open,
// one cell a cycle, and holds req_stall for the whole sweep. One request
// is in flight at a time and each gives exactly one response. A find first
// clears the cost RAM, then for every expanded cell pops the open-set heap,
// visits up to eight neighbours and, for each neighbour whose cost
// improves, computes the heuristic square root and inserts into the heap.
// A found path is then walked back through the parent RAM, once to count
// its cells and once to store them. The open set holds OPEN_DEPTH entries;
// an insert into a full open set ends the search with the overflow status.
module grid_astar_path_search import gastar_pkg::*; #(
   parameter int OPEN_DEPTH = 8192
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   localparam int AW = $clog2(OPEN_DEPTH);
   localparam int IW = AW + 2;
   localparam int HW = $bits(heap_entry_type);
   localparam int CW = $bits(cost_entry_type);

   gastar_state_type state_ff, state_in;

   logic [DIM_W-1:0]   grid_w_ff, grid_h_ff;
   logic [CELL_W-1:0]  clr_ff, clr_in;
   logic [LEN_W-1:0]   stored_len_ff, stored_len_in;
   logic [1:0]         status_ff, status_in;
   logic [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [CELL_W-1:0]  cur_ff, cur_in;
   logic [COST_W-1:0]  g_ff, g_in, tg_ff, tg_in;
   logic [2:0]         k_ff, k_in;
   heap_entry_type     item_ff, item_in, left_ff, left_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW:0]        count_ff, count_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               ret_nb_ff, ret_nb_in;
   logic [CELL_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]   len_ff, len_in, pos_ff, pos_in;

   // RAM ports
   logic               map_we, map_wdata, map_rdata;
   logic [CELL_W-1:0]  map_waddr, map_raddr;
   logic               cost_we;
   logic [CELL_W-1:0]  cost_waddr, cost_raddr;
   cost_entry_type     cost_wdata, cost_rdata;
   logic               par_we;
   logic [CELL_W-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
   logic               path_we;
   logic [CELL_W-1:0]  path_waddr, path_wdata, path_raddr, path_rdata;
   logic               heap_we;
   logic [AW-1:0]      heap_waddr, heap_raddr;
   heap_entry_type     heap_wdata, heap_rdata;

   logic               sq_start, sq_done;
   logic [COORD_W-1:0] sq_x, sq_y;
   logic [SQRT_R_W-1:0] sq_root;

   // neighbour and heap index arithmetic
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic signed [6:0]  nx_s, ny_s;
   logic               nb_off;
   logic [CELL_W-1:0]  nc;
   logic [COST_W:0]    tg_sum;
   logic [COST_W-1:0]  tg_sat;
   logic [IW-1:0]      l_idx, r_idx, cnt_w, m_idx;
   logic [AW-1:0]      p_idx;
   heap_entry_type     left_v, best;
   logic               req_accept;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_data   = '{status: status_ff, path_length: stored_len_ff,
                         path_x: px_ff, path_y: py_ff};

   always_comb begin
      // width and height above the map size act as the map size
      w_eff  = (grid_w_ff > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : grid_w_ff;
      h_eff  = (grid_h_ff > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : grid_h_ff;
      nx_s   = $signed({2'b00, cur_ff[COORD_W-1:0]}) + 7'(STEP_DX[k_ff]);
      ny_s   = $signed({2'b00, cur_ff[CELL_W-1:COORD_W]}) + 7'(STEP_DY[k_ff]);
      nb_off = nx_s[6] || ny_s[6] || (nx_s[5:0] >= w_eff) || (ny_s[5:0] >= h_eff);
      nc     = {ny_s[COORD_W-1:0], nx_s[COORD_W-1:0]};
      tg_sum = {1'b0, g_ff} + {1'b0, (k_ff[2] ? DIAG_COST : STRAIGHT_COST)};
      tg_sat = tg_sum[COST_W] ? COST_MAX : tg_sum[COST_W-1:0];
      l_idx  = IW'({i_ff, 1'b1});
      r_idx  = l_idx + IW'(1);
      cnt_w  = IW'(count_ff);
      p_idx  = (i_ff - AW'(1)) >> 1;
      // pick the smallest of the sinking entry and its children
      left_v = (state_ff == S_DN_L) ? heap_rdata : left_ff;
      best   = item_ff;
      m_idx  = IW'(i_ff);
      if (heap_before(left_v, item_ff)) begin
         best  = left_v;
         m_idx = l_idx;
      end
      if ((state_ff == S_DN_R) && heap_before(heap_rdata, best)) begin
         best  = heap_rdata;
         m_idx = r_idx;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      stored_len_in = stored_len_ff;
      status_in     = status_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      cur_in        = cur_ff;
      g_in          = g_ff;
      tg_in         = tg_ff;
      k_in          = k_ff;
      item_in       = item_ff;
      left_in       = left_ff;
      i_in          = i_ff;
      count_in      = count_ff;
      seq_in        = seq_ff;
      ret_nb_in     = ret_nb_ff;
      n_in          = n_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;

      map_we     = 1'b0;
      map_waddr  = clr_ff;
      map_wdata  = 1'b0;
      map_raddr  = nc;
      cost_we    = 1'b0;
      cost_waddr = nc;
      cost_wdata = '{closed: 1'b0, cost: COST_MAX};
      cost_raddr = nc;
      par_we     = 1'b0;
      par_waddr  = nc;
      par_wdata  = cur_ff;
      par_raddr  = n_ff;
      path_we    = 1'b0;
      path_waddr = pos_ff[CELL_W-1:0] - CELL_W'(1);
      path_wdata = n_ff;
      path_raddr = req_data.path_index;
      heap_we    = 1'b0;
      heap_waddr = i_ff;
      heap_wdata = item_ff;
      heap_raddr = p_idx;
      sq_start   = 1'b0;
      sq_x       = nx_s[COORD_W-1:0];
      sq_y       = ny_s[COORD_W-1:0];

      case (state_ff)
         S_MAP_CLR: begin
            // sweep the map to open after reset
            map_we = 1'b1;
            clr_in = clr_ff + CELL_W'(1);
            if (clr_ff == CELL_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               status_in = ST_OK;
               px_in     = '0;
               py_in     = '0;
               state_in  = S_RESP;
               case (req_data.req_type)
                  REQ_WRITE: begin
                     map_we    = 1'b1;
                     map_waddr = {req_data.cell_y, req_data.cell_x};
                     map_wdata = req_data.blocked;
                  end
                  REQ_FIND: begin
                     // drop the previous path and open set
                     stored_len_in = '0;
                     count_in      = '0;
                     seq_in        = '0;
                     sx_in         = req_data.cell_x;
                     sy_in         = req_data.cell_y;
                     gx_in         = req_data.goal_x;
                     gy_in         = req_data.goal_y;
                     map_raddr     = {req_data.goal_y, req_data.goal_x};
                     state_in      = S_GOAL_CHK;
                  end
                  REQ_READ: begin
                     if (LEN_W'(req_data.path_index) < stored_len_ff) begin
                        state_in = S_RD_WAIT;
                     end else begin
                        status_in = ST_NO_PATH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            px_in    = path_rdata[COORD_W-1:0];
            py_in    = path_rdata[CELL_W-1:COORD_W];
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         S_GOAL_CHK: begin
            if (map_rdata || ({1'b0, gx_ff} >= w_eff) || ({1'b0, gy_ff} >= h_eff)
                || ({1'b0, sx_ff} >= w_eff) || ({1'b0, sy_ff} >= h_eff)) begin
               status_in = ST_NO_PATH;
               state_in  = S_RESP;
            end else begin
               clr_in   = '0;
               state_in = S_COST_CLR;
            end
         end
         S_COST_CLR: begin
            // every cell back to maximum cost and not closed
            cost_we    = 1'b1;
            cost_waddr = clr_ff;
            clr_in     = clr_ff + CELL_W'(1);
            if (clr_ff == CELL_W'(CELLS - 1)) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cost_we    = 1'b1;
            cost_waddr = {sy_ff, sx_ff};
            cost_wdata = '{closed: 1'b0, cost: '0};
            sq_start   = 1'b1;
            sq_x       = sx_ff;
            sq_y       = sy_ff;
            state_in   = S_START_H;
         end
         S_START_H: begin
            if (sq_done) begin
               item_in   = '{f: F_W'(sq_root), seq: seq_ff, cell_id: {sy_ff, sx_ff}};
               i_in      = count_ff[AW-1:0];
               count_in  = count_ff + (AW+1)'(1);
               seq_in    = seq_ff + SEQ_W'(1);
               ret_nb_in = 1'b0;
               state_in  = S_UP;
            end
         end
         S_UP: begin
            if (i_ff == '0) begin
               heap_we  = 1'b1;
               state_in = ret_nb_ff ? S_NB_NEXT : S_POP;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            heap_we = 1'b1;
            if (heap_before(item_ff, heap_rdata)) begin
               // move the parent down into the hole
               heap_wdata = heap_rdata;
               i_in       = p_idx;
               state_in   = S_UP;
            end else begin
               state_in = ret_nb_ff ? S_NB_NEXT : S_POP;
            end
         end
         S_POP: begin
            heap_raddr = '0;
            if (count_ff == '0) begin
               status_in = ST_NO_PATH;
               state_in  = S_RESP;
            end else begin
               state_in = S_POP_TOP;
            end
         end
         S_POP_TOP: begin
            cur_in     = heap_rdata.cell_id;
            heap_raddr = AW'(count_ff - (AW+1)'(1));
            count_in   = count_ff - (AW+1)'(1);
            state_in   = S_POP_LAST;
         end
         S_POP_LAST: begin
            item_in  = heap_rdata;
            i_in     = '0;
            state_in = S_DN;
         end
         S_DN: begin
            heap_raddr = l_idx[AW-1:0];
            if (l_idx < cnt_w) begin
               state_in = S_DN_L;
            end else begin
               heap_we  = 1'b1;
               state_in = S_EXP_RD;
            end
         end
         S_DN_L, S_DN_R: begin
            left_in    = left_v;
            heap_raddr = r_idx[AW-1:0];
            if ((state_ff == S_DN_L) && (r_idx < cnt_w)) begin
               state_in = S_DN_R;
            end else begin
               heap_we = 1'b1;
               if (m_idx == IW'(i_ff)) begin
                  state_in = S_EXP_RD;
               end else begin
                  heap_wdata = best;
                  i_in       = m_idx[AW-1:0];
                  state_in   = S_DN;
               end
            end
         end
         S_EXP_RD: begin
            cost_raddr = cur_ff;
            state_in   = S_EXP_CHK;
         end
         S_EXP_CHK: begin
            if (cost_rdata.closed) begin
               state_in = S_POP;
            end else begin
               cost_we    = 1'b1;
               cost_waddr = cur_ff;
               cost_wdata = '{closed: 1'b1, cost: cost_rdata.cost};
               g_in       = cost_rdata.cost;
               if (cur_ff == {gy_ff, gx_ff}) begin
                  n_in     = cur_ff;
                  len_in   = LEN_W'(1);
                  state_in = S_PL;
               end else begin
                  k_in     = '0;
                  state_in = S_NB;
               end
            end
         end
         S_NB: begin
            state_in = nb_off ? S_NB_NEXT : S_NB_BLK;
         end
         S_NB_BLK: begin
            state_in = map_rdata ? S_NB_NEXT : S_NB_COST;
         end
         S_NB_COST: begin
            if (tg_sat < cost_rdata.cost) begin
               cost_we    = 1'b1;
               cost_wdata = '{closed: cost_rdata.closed, cost: tg_sat};
               par_we     = 1'b1;
               tg_in      = tg_sat;
               if (count_ff >= (AW+1)'(OPEN_DEPTH)) begin
                  count_in  = '0;
                  status_in = ST_OVERFLOW;
                  state_in  = S_RESP;
               end else begin
                  sq_start = 1'b1;
                  state_in = S_NB_H;
               end
            end else begin
               state_in = S_NB_NEXT;
            end
         end
         S_NB_H: begin
            if (sq_done) begin
               item_in   = '{f: F_W'(tg_ff) + F_W'(sq_root), seq: seq_ff, cell_id: nc};
               i_in      = count_ff[AW-1:0];
               count_in  = count_ff + (AW+1)'(1);
               seq_in    = seq_ff + SEQ_W'(1);
               ret_nb_in = 1'b1;
               state_in  = S_UP;
            end
         end
         S_NB_NEXT: begin
            k_in     = k_ff + 3'd1;
            state_in = (k_ff == 3'd7) ? S_POP : S_NB;
         end
         S_PL: begin
            // count the cells from goal back to start
            if ((n_ff == {sy_ff, sx_ff}) || (len_ff >= LEN_W'(CELLS))) begin
               n_in     = {gy_ff, gx_ff};
               pos_in   = len_ff;
               state_in = S_PW;
            end else begin
               state_in = S_PL_WAIT;
            end
         end
         S_PL_WAIT: begin
            n_in     = par_rdata;
            len_in   = len_ff + LEN_W'(1);
            state_in = S_PL;
         end
         S_PW: begin
            path_we = 1'b1;
            if (pos_ff == '0) begin
               path_waddr    = '0;
               path_wdata    = {sy_ff, sx_ff};
               stored_len_in = len_ff;
               status_in     = ST_FOUND;
               state_in      = S_RESP;
            end else begin
               state_in = S_PW_WAIT;
            end
         end
         S_PW_WAIT: begin
            n_in     = par_rdata;
            pos_in   = pos_ff - LEN_W'(1);
            state_in = S_PW;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_MAP_CLR;
         clr_ff        <= '0;
         stored_len_ff <= '0;
         count_ff      <= '0;
         seq_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         stored_len_ff <= stored_len_in;
         count_ff      <= count_in;
         seq_ff        <= seq_in;
      end
   end

   // the user must write the registers only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= DIM_W'(GRID_SIDE);
         grid_h_ff <= DIM_W'(GRID_SIDE);
      end else if (csr_wr_en) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            grid_w_ff <= csr_wdata;
         end
         if (csr_index == CSR_GRID_HEIGHT) begin
            grid_h_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      cur_ff    <= cur_in;
      g_ff      <= g_in;
      tg_ff     <= tg_in;
      k_ff      <= k_in;
      item_ff   <= item_in;
      left_ff   <= left_in;
      i_ff      <= i_in;
      ret_nb_ff <= ret_nb_in;
      n_ff      <= n_in;
      len_ff    <= len_in;
      pos_ff    <= pos_in;
   end

   gastar_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   gastar_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_cost (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (cost_waddr),
      .wr_data (cost_wdata),
      .rd_addr (cost_raddr),
      .rd_data (cost_rdata)
   );

   gastar_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   gastar_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
      .clock   (clock),
      .wr_en   (path_we),
      .wr_addr (path_waddr),
      .wr_data (path_wdata),
      .rd_addr (path_raddr),
      .rd_data (path_rdata)
   );

   gastar_ram #(.WIDTH(HW), .DEPTH(OPEN_DEPTH)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   gastar_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .pos_x  (sq_x),
      .pos_y  (sq_y),
      .goal_x (gx_ff),
      .goal_y (gy_ff),
      .done   (sq_done),
      .root   (sq_root)
   );

endmodule
`default_nettype wire

### sv/gastar_ram.sv
`default_nettype none
module gastar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/gastar_sqrt.sv
`default_nettype none
module gastar_sqrt import gastar_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [COORD_W-1:0]  pos_x,
   input  logic [COORD_W-1:0]  pos_y,
   input  logic [COORD_W-1:0]  goal_x,
   input  logic [COORD_W-1:0]  goal_y,
   output logic                done,
   output logic [SQRT_R_W-1:0] root
);

   localparam logic [SQRT_V_W-1:0] BIT_TOP = SQRT_V_W'(1) << (SQRT_V_W - 2);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQRT_V_W-1:0] v_ff, v_in;
   logic [SQRT_V_W-1:0] r_ff, r_in;
   logic [SQRT_V_W-1:0] bit_ff, bit_in;
   logic [COORD_W-1:0]  dx, dy;
   logic [SUMSQ_W-1:0]  sumsq;
   logic [SQRT_V_W-1:0] trial;

   always_comb begin
      dx    = (pos_x > goal_x) ? pos_x - goal_x : goal_x - pos_x;
      dy    = (pos_y > goal_y) ? pos_y - goal_y : goal_y - pos_y;
      sumsq = SUMSQ_W'(dx * dx) + SUMSQ_W'(dy * dy);
      trial = r_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = SQRT_V_W'(sumsq) << (2 * COST_FRAC_BITS);
         r_in    = '0;
         bit_in  = BIT_TOP;
      end else if (busy_ff) begin
         // one result bit per cycle
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SQRT_V_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[SQRT_R_W-1:0];

endmodule
`default_nettype wire

### sv/gastar_checker.sv
`default_nettype none
module gastar_checker import gastar_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in work");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response waits");

   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FOUND) |-> rsp_data.path_length != '0)
      else $error("found path with no cells");

   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_OVERFLOW) |-> rsp_data.path_length == '0)
      else $error("overflow left a stored path");

endmodule

bind grid_astar_path_search gastar_checker u_checker (.*);
`default_nettype wire

### test/tb_grid_astar_path_search.sv
`default_nettype none
module tb_grid_astar_path_search;
   import gastar_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_item_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_item_type       rsp_data;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = CSR_GRID_WIDTH;
   logic [DIM_W-1:0]   csr_wdata = '0;

   grid_astar_path_search dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Search model: own copy of the map, cost table, open set and path
   // ---------------------------------------------------------------------
   localparam int HEAP_CAP = 8192;

   int unsigned  cols_reg, rows_reg;
   bit           cell_wall [CELLS];
   int unsigned  g_cost [CELLS];
   int unsigned  came_from [CELLS];
   bit           visited [CELLS];
   int unsigned  open_f [HEAP_CAP];
   int unsigned  open_seq [HEAP_CAP];
   int unsigned  open_cell [HEAP_CAP];
   int unsigned  open_n, push_ctr;
   int unsigned  route [CELLS];
   int unsigned  route_len;
   int           nb_dx [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
   int           nb_dy [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic int unsigned dist_est(int x, int y, int gx, int gy);
      longint unsigned dx, dy;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      return int'(root_floor((dx * dx + dy * dy) << (2 * COST_FRAC_BITS)));
   endfunction

   function automatic bit ahead_of(int a, int b);
      return open_f[a] < open_f[b] || (open_f[a] == open_f[b] && open_seq[a] < open_seq[b]);
   endfunction

   function automatic void swap_open(int a, int b);
      int unsigned tf, ts, tc;
      tf = open_f[a]; ts = open_seq[a]; tc = open_cell[a];
      open_f[a] = open_f[b]; open_seq[a] = open_seq[b]; open_cell[a] = open_cell[b];
      open_f[b] = tf; open_seq[b] = ts; open_cell[b] = tc;
   endfunction

   function automatic bit open_insert(int unsigned f, int unsigned c);
      int i, p;
      if (open_n >= HEAP_CAP) return 1'b0;
      i = open_n++;
      open_f[i] = f; open_seq[i] = push_ctr++; open_cell[i] = c;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ahead_of(i, p)) break;
         swap_open(i, p);
         i = p;
      end
      return 1'b1;
   endfunction

   function automatic int unsigned open_take();
      int unsigned top;
      int i, l, r, m;
      top = open_cell[0];
      open_n--;
      open_f[0] = open_f[open_n]; open_seq[0] = open_seq[open_n];
      open_cell[0] = open_cell[open_n];
      i = 0;
      forever begin
         l = 2 * i + 1; r = l + 1; m = i;
         if (l < open_n && ahead_of(l, m)) m = l;
         if (r < open_n && ahead_of(r, m)) m = r;
         if (m == i) break;
         swap_open(i, m);
         i = m;
      end
      return top;
   endfunction

   function automatic bit impassable(int x, int y, int w, int h);
      if (x < 0 || y < 0 || x >= w || y >= h) return 1'b1;
      return cell_wall[y * GRID_SIDE + x];
   endfunction

   function automatic logic [1:0] search(int sx, int sy, int gx, int gy);
      int w, h, nx, ny, k, len, pos;
      int unsigned start, goal, c, nc, tg, n;
      w = (cols_reg > GRID_SIDE) ? GRID_SIDE : cols_reg;
      h = (rows_reg > GRID_SIDE) ? GRID_SIDE : rows_reg;
      route_len = 0; open_n = 0; push_ctr = 0;
      if (impassable(gx, gy, w, h)) return ST_NO_PATH;
      if (sx >= w || sy >= h) return ST_NO_PATH;
      for (int i = 0; i < CELLS; i++) begin
         g_cost[i] = COST_MAX;
         visited[i] = 1'b0;
      end
      start = sy * GRID_SIDE + sx;
      goal = gy * GRID_SIDE + gx;
      g_cost[start] = 0;
      void'(open_insert(dist_est(sx, sy, gx, gy), start));
      while (open_n > 0) begin
         c = open_take();
         if (visited[c]) continue;
         visited[c] = 1'b1;
         if (c == goal) begin
            len = 1; n = goal;
            while (n != start && len < CELLS) begin
               n = came_from[n];
               len++;
            end
            n = goal;
            for (pos = len; pos > 0; pos--) begin
               route[pos - 1] = n;
               n = came_from[n];
            end
            route[0] = start;
            route_len = len;
            return ST_FOUND;
         end
         for (k = 0; k < 8; k++) begin
            nx = int'(c % GRID_SIDE) + nb_dx[k];
            ny = int'(c / GRID_SIDE) + nb_dy[k];
            if (impassable(nx, ny, w, h)) continue;
            tg = g_cost[c] + ((nb_dx[k] == 0 || nb_dy[k] == 0) ? STRAIGHT_COST : DIAG_COST);
            if (tg > COST_MAX) tg = COST_MAX;
            nc = ny * GRID_SIDE + nx;
            if (tg < g_cost[nc]) begin
               g_cost[nc] = tg;
               came_from[nc] = c;
               if (!open_insert(tg + dist_est(nx, ny, gx, gy), nc)) begin
                  open_n = 0;
                  return ST_OVERFLOW;
               end
            end
         end
      end
      return ST_NO_PATH;
   endfunction

   function automatic rsp_item_type model_answer(req_item_type r);
      rsp_item_type o;
      o = '0;
      case (r.req_type)
         REQ_WRITE: cell_wall[r.cell_y * GRID_SIDE + r.cell_x] = r.blocked;
         REQ_FIND:  o.status = search(r.cell_x, r.cell_y, r.goal_x, r.goal_y);
         REQ_READ: begin
            if (r.path_index < route_len) begin
               o.path_x = COORD_W'(route[r.path_index] % GRID_SIDE);
               o.path_y = COORD_W'(route[r.path_index] / GRID_SIDE);
            end else begin
               o.status = ST_NO_PATH;
            end
         end
         default: ;  // unknown request: no effect
      endcase
      o.path_length = LEN_W'(route_len);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: present queued requests, with random gaps between transfers
   // ---------------------------------------------------------------------
   req_item_type  pending_reqs [$];
   rsp_item_type  awaited_rsps [$];
   bit            req_taken = 1'b0;
   bit            idle_on = 1'b1;
   int            req_gap = 0;
   int            fails = 0;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!idle_on || roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   bit  hold_wanted = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   always @(negedge clock) begin
      if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each request transfer, check each response
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && req_valid && !req_stall) begin
         want = model_answer(req_data);
         awaited_rsps = {awaited_rsps, want};
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsps.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $realtime, rsp_data);
            fails++;
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_data.status);
               fails++;
            end
            if (rsp_data.path_length !== want.path_length) begin
               $display("%0t: path_length expected %0d actual %0d", $realtime,
                        want.path_length, rsp_data.path_length);
               fails++;
            end
            if (rsp_data.path_x !== want.path_x) begin
               $display("%0t: path_x expected %0d actual %0d", $realtime,
                        want.path_x, rsp_data.path_x);
               fails++;
            end
            if (rsp_data.path_y !== want.path_y) begin
               $display("%0t: path_y expected %0d actual %0d", $realtime,
                        want.path_y, rsp_data.path_y);
               fails++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_item_type make_req(logic [1:0] kind, int x, int y, bit blk,
                                             int gx, int gy, int idx);
      req_item_type r;
      r.req_type = kind; r.cell_x = COORD_W'(x); r.cell_y = COORD_W'(y); r.blocked = blk;
      r.goal_x = COORD_W'(gx); r.goal_y = COORD_W'(gy); r.path_index = CELL_W'(idx);
      return r;
   endfunction

   task automatic set_dim(logic idx, int val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(val);
      if (idx == CSR_GRID_WIDTH) cols_reg = val[DIM_W-1:0];
      else rows_reg = val[DIM_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold until every queued request has transferred and every response is in
   task automatic drain();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic put(req_item_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   // random request: mostly aimed inside the used area so searches go deep
   function automatic req_item_type random_req(int w, int h);
      req_item_type r;
      int roll;
      r = req_item_type'({$urandom, $urandom});
      roll = $urandom_range(99);
      if ($urandom_range(9) != 0) begin
         r.cell_x = COORD_W'($urandom_range(w - 1));
         r.cell_y = COORD_W'($urandom_range(h - 1));
         r.goal_x = COORD_W'($urandom_range(w - 1));
         r.goal_y = COORD_W'($urandom_range(h - 1));
      end
      if (roll < 30) begin
         r.req_type = REQ_WRITE;
         r.blocked = ($urandom_range(99) < 30);
      end else if (roll < 55) begin
         r.req_type = REQ_FIND;
      end else if (roll < 95) begin
         r.req_type = REQ_READ;
         if ($urandom_range(9) != 0) r.path_index = CELL_W'($urandom_range(20));
      end else begin
         r.req_type = REQ_UNKNOWN;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int w, h;
      cols_reg = GRID_SIDE; rows_reg = GRID_SIDE;
      route_len = 0; open_n = 0;
      for (int i = 0; i < CELLS; i++) begin
         cell_wall[i] = 1'b0;
         came_from[i] = 0;
         route[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full grid, extremes and the corner cases
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));            // no path stored yet
      put(make_req(REQ_UNKNOWN, 31, 31, 1, 31, 31, 1023));   // unknown request
      put(make_req(REQ_WRITE, 31, 31, 1, 0, 0, 0));
      put(make_req(REQ_FIND, 0, 0, 0, 31, 31, 0));           // goal blocked
      put(make_req(REQ_WRITE, 31, 31, 0, 31, 31, 1023));
      put(make_req(REQ_FIND, 0, 0, 0, 31, 31, 0));           // long diagonal
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 31));
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 32));            // past the end
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 1023));
      put(make_req(REQ_FIND, 5, 5, 0, 5, 5, 0));             // start equals goal
      put(make_req(REQ_WRITE, 3, 3, 1, 0, 0, 0));
      put(make_req(REQ_FIND, 3, 3, 0, 6, 4, 0));             // blocked start
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 1));
      put(make_req(REQ_WRITE, 1, 0, 1, 0, 0, 0));
      put(make_req(REQ_WRITE, 0, 1, 1, 0, 0, 0));
      put(make_req(REQ_FIND, 0, 0, 0, 1, 1, 0));             // corner cutting
      put(make_req(REQ_READ, 0, 0, 0, 0, 0, 1));
      drain();

      // registers out of range: zero height puts everything off the grid
      set_dim(CSR_GRID_WIDTH, 63);
      set_dim(CSR_GRID_HEIGHT, 0);
      put(make_req(REQ_FIND, 0, 0, 0, 0, 0, 0));
      drain();
      set_dim(CSR_GRID_WIDTH, 0);
      set_dim(CSR_GRID_HEIGHT, 63);
      put(make_req(REQ_FIND, 0, 0, 0, 0, 0, 0));
      drain();

      // small area: off-grid start, write outside the used area, walled goal
      set_dim(CSR_GRID_WIDTH, 4);
      set_dim(CSR_GRID_HEIGHT, 3);
      put(make_req(REQ_FIND, 0, 2, 0, 3, 0, 0));
      put(make_req(REQ_FIND, 5, 0, 0, 1, 1, 0));
      put(make_req(REQ_WRITE, 10, 10, 1, 0, 0, 0));
      for (int y = 0; y < 3; y++) put(make_req(REQ_WRITE, 2, y, 1, 0, 0, 0));
      put(make_req(REQ_FIND, 0, 0, 0, 3, 0, 0));           // wall: no path
      drain();

      // long receiver hold-off while the sender keeps offering transfers
      hold_wanted = 1'b1;
      for (int i = 0; i < 12; i++) put(random_req(4, 3));
      drain();

      // random phases over several area sizes, one at full size
      for (int ph = 0; ph < 4; ph++) begin
         if (ph == 2) begin
            w = GRID_SIDE; h = GRID_SIDE;
         end else begin
            w = $urandom_range(10, 1); h = $urandom_range(10, 1);
         end
         set_dim(CSR_GRID_WIDTH, w);
         set_dim(CSR_GRID_HEIGHT, h);
         idle_on = (ph != 3);   // one phase runs back to back
         for (int i = 0; i < 16; i++) put(random_req(w, h));
         drain();
      end
      idle_on = 1'b1;

      repeat (50) @(posedge clock);
      if (fails == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #3000ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire

### grid_astar_path_search.f
sv/gastar_pkg.sv
sv/gastar_ram.sv
sv/gastar_sqrt.sv
sv/grid_astar_path_search.sv
sv/gastar_checker.sv
test/tb_grid_astar_path_search.sv
